### rtl/i2cr_pkg.sv
`timescale 1ns / 1ps

package i2cr_pkg;

    localparam int MAX_BYTES_DEF = 4;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [6:0]  DEV_ADDR_RST = 7'h38;
    localparam logic [15:0] TPU_RST      = 16'd48;
    localparam logic [7:0]  ACK_TO_RST   = 8'd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEV_ADDR = 2'd0,
        CFG_TPU      = 2'd1,
        CFG_ACK_TO   = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START_HI  = 5'd1,
        PH_START_LO  = 5'd2,
        PH_TX_SET    = 5'd3,
        PH_TX_HI     = 5'd4,
        PH_TX_LO     = 5'd5,
        PH_ACK_LO    = 5'd6,
        PH_ACK_HI    = 5'd7,
        PH_ACK_POLL  = 5'd8,
        PH_RX_LO     = 5'd9,
        PH_RX_SAMPLE = 5'd10,
        PH_RX_HI     = 5'd11,
        PH_MACK_LO   = 5'd12,
        PH_MACK_HI   = 5'd13,
        PH_STOP_LO   = 5'd14,
        PH_STOP_HI   = 5'd15,
        PH_DONE      = 5'd16,
        PH_STOP_LO_E = 5'd17,
        PH_STOP_HI_E = 5'd18,
        PH_DONE_E    = 5'd19
    } phase_t;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [15:0] ticks_per_unit;
        logic [7:0]  ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic        sda_in;
        logic [2:0]  byte_count;
        logic [15:0] reg_addr;
        logic        start_req;
    } in_item_t;

    typedef struct packed {
        logic [31:0] rx_data;
        logic        ack_error;
        logic        done_res;
        logic        busy_res;
        logic        sda_release;
        logic        scl;
    } out_item_t;

endpackage

### rtl/i2c_master_register_reader.sv
`timescale 1ns / 1ps

// I2C master that reads 1 to MAX_BYTES data bytes from a 16-bit register address, one
// bus tick per transfer: every input transfer is one tick and yields exactly one result
// transfer with the pin levels and status of that tick. A transfer is held in an input
// register and stepped through the sequencer into the output register as soon as that
// register is free or being emptied, so the block sustains one tick per clock cycle and
// each result is registered in the output register after its input has been held in the
// input register; the only thing that slows it is back-pressure on the result channel.
module i2c_master_register_reader #(
    parameter int MAX_BYTES = i2cr_pkg::MAX_BYTES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // start_req, reg_addr[15:0], byte_count[2:0], sda_in, zero fill
    input  logic [i2cr_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // scl, sda_release, busy_res, done_res, ack_error, rx_data[31:0], zero fill
    output logic [i2cr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [i2cr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [i2cr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import i2cr_pkg::*;

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t step_res;
    logic      advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_item_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= DEV_ADDR_RST;
            cfg_reg.ticks_per_unit <= TPU_RST;
            cfg_reg.ack_timeout    <= ACK_TO_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEV_ADDR: cfg_reg.device_address <= cfg_data[6:0];
                CFG_TPU:      cfg_reg.ticks_per_unit <= cfg_data;
                CFG_ACK_TO:   cfg_reg.ack_timeout    <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
        end
        if (advance) begin
            out_item_reg <= step_res;
        end
    end

    i2cr_seq #(
        .MAX_BYTES(MAX_BYTES)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

endmodule

### rtl/i2cr_seq.sv
`timescale 1ns / 1ps

module i2cr_seq #(
    parameter int MAX_BYTES = i2cr_pkg::MAX_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  i2cr_pkg::in_item_t  item,
    input  i2cr_pkg::cfg_t      cfg,
    output i2cr_pkg::out_item_t res
);
    import i2cr_pkg::*;

    localparam int BlW = $clog2(MAX_BYTES + 1);

    phase_t         phase_reg, phase_next;
    logic [3:0]     bit_index_reg, bit_index_next;
    logic [BlW-1:0] bytes_left_reg, bytes_left_next;
    logic [7:0]     shift_byte_reg, shift_byte_next;
    logic [31:0]    data_accum_reg, data_accum_next;
    logic [17:0]    delay_left_reg, delay_left_next;
    logic [7:0]     timeout_left_reg, timeout_left_next;
    logic [15:0]    held_address_reg, held_address_next;

    logic [15:0] unit;
    logic [17:0] d1, d2, d4;
    logic        over;
    logic        rx_end;

    assign unit = (cfg.ticks_per_unit == 16'd0) ? 16'd1 : cfg.ticks_per_unit;
    assign d1   = {2'b00, unit};
    assign d2   = {1'b0, unit, 1'b0};
    assign d4   = {unit, 2'b00};

    always_comb begin
        phase_next        = phase_reg;
        bit_index_next    = bit_index_reg;
        bytes_left_next   = bytes_left_reg;
        shift_byte_next   = shift_byte_reg;
        data_accum_next   = data_accum_reg;
        delay_left_next   = delay_left_reg;
        timeout_left_next = timeout_left_reg;
        held_address_next = held_address_reg;
        rx_end            = 1'b0;
        res               = '0;
        res.scl           = 1'b1;
        res.sda_release   = 1'b1;
        res.busy_res      = 1'b1;

        if (phase_reg == PH_IDLE && item.start_req) begin
            held_address_next = item.reg_addr;
            if (item.byte_count == 3'd0) begin
                bytes_left_next = BlW'(1);
            end else if (int'(item.byte_count) > MAX_BYTES) begin
                bytes_left_next = BlW'(MAX_BYTES);
            end else begin
                bytes_left_next = BlW'(item.byte_count);
            end
            shift_byte_next = {cfg.device_address, 1'b0};
            data_accum_next = 32'd0;
            bit_index_next  = 4'd0;
            phase_next      = PH_START_HI;
            delay_left_next = d4;
        end

        over = (delay_left_next <= 18'd1);
        if (!over) begin
            delay_left_next = delay_left_next - 18'd1;
        end

        unique case (phase_next)
            PH_IDLE: begin
                res.busy_res = 1'b0;
            end
            PH_START_HI: begin
                if (over) begin
                    phase_next      = PH_START_LO;
                    delay_left_next = d4;
                end
            end
            PH_START_LO: begin
                res.sda_release = 1'b0;
                if (over) begin
                    bit_index_next  = 4'd0;
                    phase_next      = PH_TX_SET;
                    delay_left_next = d2;
                end
            end
            PH_TX_SET: begin
                res.scl         = 1'b0;
                res.sda_release = shift_byte_next[7];
                if (over) begin
                    phase_next      = PH_TX_HI;
                    delay_left_next = d2;
                end
            end
            PH_TX_HI: begin
                res.sda_release = shift_byte_next[7];
                if (over) begin
                    phase_next      = PH_TX_LO;
                    delay_left_next = d2;
                end
            end
            PH_TX_LO: begin
                res.scl         = 1'b0;
                res.sda_release = shift_byte_next[7];
                if (over) begin
                    shift_byte_next = {shift_byte_next[6:0], 1'b0};
                    bit_index_next  = bit_index_next + 4'd1;
                    if (bit_index_next >= 4'd8) begin
                        phase_next      = PH_ACK_LO;
                        delay_left_next = d1;
                    end else begin
                        phase_next      = PH_TX_SET;
                        delay_left_next = d2;
                    end
                end
            end
            PH_ACK_LO: begin
                res.scl = 1'b0;
                if (over) begin
                    phase_next      = PH_ACK_HI;
                    delay_left_next = d1;
                end
            end
            PH_ACK_HI: begin
                if (over) begin
                    phase_next        = PH_ACK_POLL;
                    delay_left_next   = 18'd0;
                    timeout_left_next = cfg.ack_timeout;
                end
            end
            PH_ACK_POLL: begin
                if (!item.sda_in) begin
                    bit_index_next = 4'd0;
                    if (data_accum_next == 32'd0) begin
                        shift_byte_next = held_address_next[15:8];
                        data_accum_next = 32'd1;
                        phase_next      = PH_TX_SET;
                        delay_left_next = d2;
                    end else if (data_accum_next == 32'd1) begin
                        shift_byte_next = held_address_next[7:0];
                        data_accum_next = 32'd2;
                        phase_next      = PH_TX_SET;
                        delay_left_next = d2;
                    end else if (data_accum_next == 32'd2) begin
                        shift_byte_next = {cfg.device_address, 1'b1};
                        data_accum_next = 32'd3;
                        phase_next      = PH_START_HI;
                        delay_left_next = d4;
                    end else begin
                        data_accum_next = 32'd0;
                        shift_byte_next = 8'd0;
                        phase_next      = PH_RX_LO;
                        delay_left_next = d2;
                    end
                end else if (timeout_left_next == 8'd0) begin
                    phase_next      = PH_STOP_LO_E;
                    delay_left_next = d4;
                end else begin
                    timeout_left_next = timeout_left_next - 8'd1;
                end
            end
            PH_RX_LO: begin
                res.scl = 1'b0;
                if (over) begin
                    phase_next      = PH_RX_SAMPLE;
                    delay_left_next = 18'd0;
                end
            end
            PH_RX_SAMPLE: begin
                shift_byte_next = {shift_byte_next[6:0], item.sda_in};
                bit_index_next  = bit_index_next + 4'd1;
                if (unit <= 16'd1) begin
                    rx_end = 1'b1;
                end else begin
                    phase_next      = PH_RX_HI;
                    delay_left_next = d1 - 18'd1;
                end
            end
            PH_RX_HI: begin
                if (over) begin
                    rx_end = 1'b1;
                end
            end
            PH_MACK_LO: begin
                res.scl         = 1'b0;
                res.sda_release = (bytes_left_next == '0);
                if (over) begin
                    phase_next      = PH_MACK_HI;
                    delay_left_next = d2;
                end
            end
            PH_MACK_HI: begin
                res.sda_release = (bytes_left_next == '0);
                if (over) begin
                    if (bytes_left_next == '0) begin
                        phase_next      = PH_STOP_LO;
                        delay_left_next = d4;
                    end else begin
                        bit_index_next  = 4'd0;
                        shift_byte_next = 8'd0;
                        phase_next      = PH_RX_LO;
                        delay_left_next = d2;
                    end
                end
            end
            PH_STOP_LO, PH_STOP_LO_E: begin
                res.scl         = 1'b0;
                res.sda_release = 1'b0;
                if (over) begin
                    phase_next      = (phase_next == PH_STOP_LO) ? PH_STOP_HI : PH_STOP_HI_E;
                    delay_left_next = d4;
                end
            end
            PH_STOP_HI, PH_STOP_HI_E: begin
                if (over) begin
                    phase_next      = (phase_next == PH_STOP_HI) ? PH_DONE : PH_DONE_E;
                    delay_left_next = 18'd0;
                end
            end
            PH_DONE: begin
                res.busy_res  = 1'b0;
                res.done_res  = 1'b1;
                res.rx_data   = data_accum_next;
                phase_next    = PH_IDLE;
            end
            PH_DONE_E: begin
                res.busy_res  = 1'b0;
                res.done_res  = 1'b1;
                res.ack_error = 1'b1;
                phase_next    = PH_IDLE;
            end
            default: begin
                res.busy_res    = 1'b0;
                phase_next      = PH_IDLE;
                delay_left_next = 18'd0;
            end
        endcase

        if (rx_end) begin
            if (bit_index_next < 4'd8) begin
                phase_next      = PH_RX_LO;
                delay_left_next = d2;
            end else begin
                data_accum_next = {data_accum_next[23:0], shift_byte_next};
                if (bytes_left_next != '0) begin
                    bytes_left_next = bytes_left_next - BlW'(1);
                end
                phase_next      = PH_MACK_LO;
                delay_left_next = d2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            bit_index_reg    <= 4'd0;
            bytes_left_reg   <= '0;
            shift_byte_reg   <= 8'd0;
            data_accum_reg   <= 32'd0;
            delay_left_reg   <= 18'd0;
            timeout_left_reg <= 8'd0;
            held_address_reg <= 16'd0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            bit_index_reg    <= bit_index_next;
            bytes_left_reg   <= bytes_left_next;
            shift_byte_reg   <= shift_byte_next;
            data_accum_reg   <= data_accum_next;
            delay_left_reg   <= delay_left_next;
            timeout_left_reg <= timeout_left_next;
            held_address_reg <= held_address_next;
        end
    end

`ifndef SYNTHESIS
    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(phase_reg) && $stable(delay_left_reg))
        else $error("sequencer state moved without a tick");

    a_start_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && phase_reg == PH_IDLE && item.start_req |=> phase_reg == PH_START_HI)
        else $error("request in idle did not open a start condition");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && (phase_reg == PH_DONE || phase_reg == PH_DONE_E) |=> phase_reg == PH_IDLE)
        else $error("done phase did not return to idle");

    a_bytes_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg <= BlW'(MAX_BYTES))
        else $error("byte count beyond maximum");

    a_bit_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_index_reg <= 4'd8)
        else $error("bit index beyond one byte");
`endif

endmodule
